>>> design/mict_pkg.sv
// Shared types, widths and status codes for the message id counter table.
package mict_pkg;

    localparam int TABLE_SLOTS = 32;

    localparam int ID_W         = 29;
    localparam int CNT_W        = 32;
    localparam int SLOT_FIELD_W = 5;
    localparam int USED_FIELD_W = 6;
    localparam int STATUS_W     = 3;

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int USED_W = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W  = (USED_W > SLOT_FIELD_W) ? USED_W : SLOT_FIELD_W;

    localparam logic [STATUS_W-1:0] STATUS_COUNTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_READ_OK  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_READ_BAD = 3'd4;

    typedef struct packed {
        logic                    kind;
        logic [ID_W-1:0]         frame_id;
        logic [SLOT_FIELD_W-1:0] read_slot;
    } mict_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [ID_W-1:0]         entry_id;
        logic [CNT_W-1:0]        entry_count;
        logic [USED_FIELD_W-1:0] slots_used;
    } mict_out_t;

endpackage

>>> design/message_id_counter_table_core.sv
// Top level: per-identifier frame counter table built around two slot memories.
//
// Counts received bus frames per 29-bit identifier in a table of TABLE_SLOTS
// slots held in two synchronous memories (identifier and count), each with one
// read port and one write port. A frame request scans the used slots one per
// cycle through the memory read port; a match increments that slot's count
// (saturating), a miss appends the identifier with count one, and a miss on a
// full table drops the frame with status 2. A read request returns one slot
// plus the number of slots in use. A frame's result waits for the scan to
// reach the matching slot or the end of the used slots; a read needs no
// scan. One request is in work at a time; the next is accepted once the
// result sits in the output register, even while that result still waits
// for m_ready. No clearing pass runs after reset: only slots below the fill
// count ever have their contents used.
module message_id_counter_table_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mict_pkg::mict_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mict_pkg::mict_out_t m_data
);
    import mict_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_READ,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic [ID_W-1:0]   fid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [USED_W-1:0] used_reg;
    mict_out_t         res_reg;
    logic              m_valid_reg;
    mict_out_t         m_data_reg;

    logic [ID_W-1:0]   id_mem  [TABLE_SLOTS];
    logic [CNT_W-1:0]  cnt_mem [TABLE_SLOTS];
    logic [ID_W-1:0]   id_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic              id_we;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;

    logic              match;
    logic              last;
    logic              full;
    logic              rd_in_range;
    logic [CNT_W-1:0]  cnt_inc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign match       = (id_rd_reg == fid_reg);
    assign last        = ((USED_W'(idx_reg) + USED_W'(1)) == used_reg);
    assign full        = (used_reg == USED_W'(TABLE_SLOTS));
    assign rd_in_range = (CMP_W'(s_data.read_slot) < CMP_W'(used_reg));
    assign cnt_inc     = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + CNT_W'(1);

    // Memory port control; a write may land on a slot read in the same request, but no
    // read result is used after a write, since only one request is in work at a time.
    always_comb begin
        raddr     = '0;
        waddr     = idx_reg;
        id_we     = 1'b0;
        cnt_we    = 1'b0;
        cnt_wdata = cnt_inc;
        case (state_reg)
            ST_IDLE: begin
                raddr = s_data.kind ? IDX_W'(s_data.read_slot) : '0;
            end
            ST_SEARCH: begin
                raddr  = idx_reg + IDX_W'(1);
                cnt_we = match;
            end
            ST_INSERT: begin
                waddr     = IDX_W'(used_reg);
                id_we     = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = CNT_W'(1);
            end
            default: begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (id_we) begin
            id_mem[waddr] <= fid_reg;
        end
        if (cnt_we) begin
            cnt_mem[waddr] <= cnt_wdata;
        end
        id_rd_reg  <= id_mem[raddr];
        cnt_rd_reg <= cnt_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg != ST_FIN && m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        fid_reg <= s_data.frame_id;
                        idx_reg <= '0;
                        if (s_data.kind) begin
                            res_reg.status      <= STATUS_READ_BAD;
                            res_reg.slot_index  <= s_data.read_slot;
                            res_reg.entry_id    <= '0;
                            res_reg.entry_count <= '0;
                            res_reg.slots_used  <= USED_FIELD_W'(used_reg);
                            state_reg <= rd_in_range ? ST_READ : ST_FIN;
                        end else if (used_reg == '0) begin
                            state_reg <= ST_INSERT;
                        end else begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_READ: begin
                    res_reg.status      <= STATUS_READ_OK;
                    res_reg.entry_id    <= id_rd_reg;
                    res_reg.entry_count <= cnt_rd_reg;
                    state_reg           <= ST_FIN;
                end
                ST_SEARCH: begin
                    res_reg.slots_used <= USED_FIELD_W'(used_reg);
                    if (match) begin
                        res_reg.status      <= STATUS_COUNTED;
                        res_reg.slot_index  <= SLOT_FIELD_W'(idx_reg);
                        res_reg.entry_id    <= id_rd_reg;
                        res_reg.entry_count <= cnt_inc;
                        state_reg           <= ST_FIN;
                    end else if (!last) begin
                        // advance to the next used slot
                        idx_reg <= idx_reg + IDX_W'(1);
                    end else if (full) begin
                        res_reg.status      <= STATUS_DROPPED;
                        res_reg.slot_index  <= '0;
                        res_reg.entry_id    <= '0;
                        res_reg.entry_count <= '0;
                        state_reg           <= ST_FIN;
                    end else begin
                        state_reg <= ST_INSERT;
                    end
                end
                ST_INSERT: begin
                    res_reg.status      <= STATUS_INSERTED;
                    res_reg.slot_index  <= SLOT_FIELD_W'(used_reg);
                    res_reg.entry_id    <= fid_reg;
                    res_reg.entry_count <= CNT_W'(1);
                    res_reg.slots_used  <= USED_FIELD_W'(used_reg + USED_W'(1));
                    used_reg            <= used_reg + USED_W'(1);
                    state_reg           <= ST_FIN;
                end
                ST_FIN: begin
                    // hold the result until the output register frees up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/mict_checker.sv
// Port-level checker for the message id counter table, bound to the top level.
module mict_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mict_pkg::mict_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mict_pkg::mict_out_t m_data
);
    import mict_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_dropped_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_DROPPED |->
            m_data.slots_used == USED_FIELD_W'(TABLE_SLOTS) && m_data.slot_index == '0 &&
            m_data.entry_id == '0 && m_data.entry_count == '0)
        else $error("drop reported with table not full or nonzero fields");

    a_inserted_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_INSERTED |->
            m_data.entry_count == CNT_W'(1) &&
            m_data.slots_used == USED_FIELD_W'(m_data.slot_index) + USED_FIELD_W'(1))
        else $error("insert not at the end of the used slots");

    a_counted_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_COUNTED |->
            m_data.entry_count != '0 &&
            USED_FIELD_W'(m_data.slot_index) < m_data.slots_used)
        else $error("count result outside the used slots");

    a_read_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_READ_BAD |->
            m_data.entry_id == '0 && m_data.entry_count == '0 &&
            USED_FIELD_W'(m_data.slot_index) >= m_data.slots_used)
        else $error("unused slot read returned data");

endmodule

bind message_id_counter_table_core mict_checker u_mict_checker (.*);
